FILE: src/bsq_pkg.sv
package bsq_pkg;

  // Default bit address width of the store
  localparam int ADDRESS_BITS_DEF = 22;

  // Instruction layout and sequencing
  localparam int VAL_W         = 52;
  localparam int FIELD_B_SHIFT = 26;
  localparam int JUMP_OFFSET   = 52;
  localparam int INSN_BITS     = 3 * 26;
  localparam int WORD_W        = 64;
  localparam int SHIFT_W       = 2 * WORD_W;

  // Channel payload widths
  localparam int OUT_ADDR_W  = 22;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 88;

  typedef enum logic [1:0] {
    OP_EXEC  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Control of the shared funnel shifter
  typedef struct packed {
    logic       deposit;  // 1: shift left (place a value), 0: shift right (pull a value)
    logic [5:0] amount;
  } shift_ctl_t;

endpackage

FILE: src/bsq_mem.sv
module bsq_mem #(
  parameter int ADDR_W = bsq_pkg::ADDRESS_BITS_DEF - 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         addr,
  input  logic [bsq_pkg::WORD_W-1:0] wdata,
  output logic [bsq_pkg::WORD_W-1:0] rdata
);

  logic [bsq_pkg::WORD_W-1:0] mem_r [2**ADDR_W];
  logic [bsq_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/bsq_shift.sv
module bsq_shift (
  input  bsq_pkg::shift_ctl_t          ctl,
  input  logic [bsq_pkg::SHIFT_W-1:0]  din,
  output logic [bsq_pkg::SHIFT_W-1:0]  dout
);

  always_comb begin
    if (ctl.deposit) begin
      dout = din << ctl.amount;
    end else begin
      dout = din >> ctl.amount;
    end
  end

endmodule

FILE: src/bit_addressed_subleq_core.sv
// Subtract-and-branch core over a bit-addressed store of 64-bit words.
// Input channel (in_*): one beat carries op, word_index and word_data. Op 0
// runs one instruction at the current instruction address, op 1 writes a
// whole word, op 2 reads one, op 3 does nothing. Every input beat yields
// exactly one output beat (out_*) with the instruction address after the
// beat, the branch flag and the read word.
// All memory traffic goes through one single-port word memory with a
// registered read, and unaligned 52-bit values are pulled and placed by
// one shared funnel shifter; a fetch spans two word reads.
// An instruction runs through fetch, two operands and two write-back
// words; one that jumps then also reads its jump target. in_tready is
// high only while the core is idle, so it takes no new beat before the
// last one's result has gone to the output register.
// Reset clears the instruction address and then sweeps the memory to
// zero, one word per cycle over all 2^(ADDRESS_BITS-6) words, 65536 by
// default, with in_tready low. A result waits in the output register while
// out_tready is low; the core may take one more beat meanwhile and holds
// its result until the output register frees.
module bit_addressed_subleq_core #(
  parameter int ADDRESS_BITS = bsq_pkg::ADDRESS_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // op [1:0], word_index [17:2], word_data [81:18], zero [87:82]
  input  logic [bsq_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // next_address [21:0], branch_taken [22], read_word [86:23], zero [87]
  output logic [bsq_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int WIDX_W = ADDRESS_BITS - 6;
  localparam int VAL_W  = bsq_pkg::VAL_W;
  localparam int WORD_W = bsq_pkg::WORD_W;
  localparam int OAW    = bsq_pkg::OUT_ADDR_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD0, S_RD1, S_RD2, S_WR0, S_WR1, S_HRD, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_INSN, PH_A, PH_B, PH_JMP
  } phase_t;

  state_t                   state_r, state_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [WIDX_W-1:0]        clr_idx_r, clr_idx_nxt;
  logic [ADDRESS_BITS-1:0]  ip_r, ip_nxt;
  logic [ADDRESS_BITS-1:0]  fetch_addr_r, fetch_addr_nxt;
  logic [ADDRESS_BITS-1:0]  a_r, a_nxt;
  logic [ADDRESS_BITS-1:0]  b_r, b_nxt;
  logic [VAL_W-1:0]         va_r, va_nxt;
  logic [VAL_W-1:0]         pat_r, pat_nxt;
  logic [WORD_W-1:0]        lo_r, lo_nxt;
  logic [WORD_W-1:0]        alo_r, alo_nxt;
  logic [WORD_W-1:0]        ahi_r, ahi_nxt;
  logic                     taken_r, taken_nxt;
  logic [WORD_W-1:0]        rdw_r, rdw_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OAW-1:0]           out_addr_r, out_addr_nxt;
  logic                     out_taken_r, out_taken_nxt;
  logic [WORD_W-1:0]        out_rdw_r, out_rdw_nxt;

  logic                     mem_we;
  logic                     mem_re;
  logic [WIDX_W-1:0]        mem_addr;
  logic [WORD_W-1:0]        mem_wdata;
  logic [WORD_W-1:0]        mem_rdata;

  bsq_pkg::shift_ctl_t          sh_ctl;
  logic [bsq_pkg::SHIFT_W-1:0]  sh_din;
  logic [bsq_pkg::SHIFT_W-1:0]  sh_dout;

  logic                     in_fire;
  bsq_pkg::op_t             in_op;
  logic [15:0]              in_word_index;
  logic [WORD_W-1:0]        in_word_data;
  logic [WIDX_W-1:0]        host_idx;
  logic [OAW-1:0]           ip_out;
  logic [WIDX_W-1:0]        fetch_idx;
  logic [WIDX_W-1:0]        a_idx;
  logic [VAL_W-1:0]         ext_val;
  logic [VAL_W-1:0]         sub_res;
  logic [ADDRESS_BITS-1:0]  ext_a;
  logic [ADDRESS_BITS-1:0]  ext_b;
  logic [ADDRESS_BITS-1:0]  jump_addr;

  assign in_tready     = (state_r == S_IDLE);
  assign in_fire       = in_tvalid && in_tready;
  assign in_op         = bsq_pkg::op_t'(in_tdata[1:0]);
  assign in_word_index = in_tdata[17:2];
  assign in_word_data  = in_tdata[81:18];

  generate
    if (WIDX_W <= 16) begin : g_idx_narrow
      assign host_idx = in_word_index[WIDX_W-1:0];
    end else begin : g_idx_wide
      assign host_idx = {{(WIDX_W-16){1'b0}}, in_word_index};
    end
    if (ADDRESS_BITS >= OAW) begin : g_out_trunc
      assign ip_out = ip_r[OAW-1:0];
    end else begin : g_out_ext
      assign ip_out = {{(OAW-ADDRESS_BITS){1'b0}}, ip_r};
    end
  endgenerate

  assign fetch_idx = fetch_addr_r[ADDRESS_BITS-1:6];
  assign a_idx     = a_r[ADDRESS_BITS-1:6];
  assign ext_val   = sh_dout[VAL_W-1:0];
  assign ext_a     = sh_dout[ADDRESS_BITS-1:0];
  assign ext_b     = sh_dout[bsq_pkg::FIELD_B_SHIFT +: ADDRESS_BITS];
  assign sub_res   = va_r - ext_val;
  assign jump_addr = ip_r + ADDRESS_BITS'(bsq_pkg::JUMP_OFFSET);

  // Shared shifter: place the write-back pattern, else pull a fetched value
  always_comb begin
    if (state_r == S_WR0 || state_r == S_WR1) begin
      sh_ctl.deposit = 1'b1;
      sh_ctl.amount  = a_r[5:0];
      sh_din         = {{(bsq_pkg::SHIFT_W-VAL_W){1'b0}}, pat_r};
    end else begin
      sh_ctl.deposit = 1'b0;
      sh_ctl.amount  = fetch_addr_r[5:0];
      sh_din         = {mem_rdata, lo_r};
    end
  end

  bsq_shift u_shift (
    .ctl  (sh_ctl),
    .din  (sh_din),
    .dout (sh_dout)
  );

  bsq_mem #(
    .ADDR_W (WIDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = fetch_idx;
    mem_wdata = '0;
    unique case (state_r)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_idx_r;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            bsq_pkg::OP_EXEC: begin
              mem_re   = 1'b1;
              mem_addr = ip_r[ADDRESS_BITS-1:6];
            end
            bsq_pkg::OP_WRITE: begin
              mem_we    = 1'b1;
              mem_addr  = host_idx;
              mem_wdata = in_word_data;
            end
            bsq_pkg::OP_READ: begin
              mem_re   = 1'b1;
              mem_addr = host_idx;
            end
            default: ;
          endcase
        end
      end
      S_RD0: begin
        mem_re = 1'b1;
      end
      S_RD1: begin
        mem_re   = 1'b1;
        mem_addr = fetch_idx + WIDX_W'(1);
      end
      S_RD2: begin
        if (phase_r == PH_INSN) begin
          mem_re   = 1'b1;
          mem_addr = ext_a[ADDRESS_BITS-1:6];
        end else if (phase_r == PH_A) begin
          mem_re   = 1'b1;
          mem_addr = b_r[ADDRESS_BITS-1:6];
        end
      end
      S_WR0: begin
        mem_we    = 1'b1;
        mem_addr  = a_idx;
        mem_wdata = alo_r ^ sh_dout[WORD_W-1:0];
      end
      S_WR1: begin
        mem_we    = 1'b1;
        mem_addr  = a_idx + WIDX_W'(1);
        mem_wdata = ahi_r ^ sh_dout[bsq_pkg::SHIFT_W-1:WORD_W];
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    clr_idx_nxt    = clr_idx_r;
    ip_nxt         = ip_r;
    fetch_addr_nxt = fetch_addr_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    va_nxt         = va_r;
    pat_nxt        = pat_r;
    lo_nxt         = lo_r;
    alo_nxt        = alo_r;
    ahi_nxt        = ahi_r;
    taken_nxt      = taken_r;
    rdw_nxt        = rdw_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_addr_nxt   = out_addr_r;
    out_taken_nxt  = out_taken_r;
    out_rdw_nxt    = out_rdw_r;
    unique case (state_r)
      S_CLR: begin
        clr_idx_nxt = clr_idx_r + WIDX_W'(1);
        if (&clr_idx_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          taken_nxt = 1'b0;
          rdw_nxt   = '0;
          case (in_op)
            bsq_pkg::OP_EXEC: begin
              fetch_addr_nxt = ip_r;
              phase_nxt      = PH_INSN;
              state_nxt      = S_RD1;
            end
            bsq_pkg::OP_READ: begin
              state_nxt = S_HRD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        lo_nxt    = mem_rdata;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        unique case (phase_r)
          PH_INSN: begin
            a_nxt          = ext_a;
            b_nxt          = ext_b;
            fetch_addr_nxt = ext_a;
            phase_nxt      = PH_A;
            state_nxt      = S_RD1;
          end
          PH_A: begin
            va_nxt         = ext_val;
            alo_nxt        = lo_r;
            ahi_nxt        = mem_rdata;
            fetch_addr_nxt = b_r;
            phase_nxt      = PH_B;
            state_nxt      = S_RD1;
          end
          PH_B: begin
            pat_nxt   = sub_res ^ va_r;
            // fall through only for results in 1 .. 2^51-1
            taken_nxt = (sub_res == '0) || sub_res[VAL_W-1];
            state_nxt = S_WR0;
          end
          PH_JMP: begin
            ip_nxt    = ext_a;
            state_nxt = S_DONE;
          end
          default: ;
        endcase
      end
      S_WR0: begin
        state_nxt = S_WR1;
      end
      S_WR1: begin
        if (taken_r) begin
          fetch_addr_nxt = jump_addr;
          phase_nxt      = PH_JMP;
          state_nxt      = S_RD0;
        end else begin
          ip_nxt    = ip_r + ADDRESS_BITS'(bsq_pkg::INSN_BITS);
          state_nxt = S_DONE;
        end
      end
      S_HRD: begin
        rdw_nxt   = mem_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = ip_out;
          out_taken_nxt = taken_r;
          out_rdw_nxt   = rdw_r;
          state_nxt     = S_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      phase_r     <= PH_INSN;
      clr_idx_r   <= '0;
      ip_r        <= '0;
      taken_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      clr_idx_r   <= clr_idx_nxt;
      ip_r        <= ip_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fetch_addr_r <= fetch_addr_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    va_r         <= va_nxt;
    pat_r        <= pat_nxt;
    lo_r         <= lo_nxt;
    alo_r        <= alo_nxt;
    ahi_r        <= ahi_nxt;
    rdw_r        <= rdw_nxt;
    out_addr_r   <= out_addr_nxt;
    out_taken_r  <= out_taken_nxt;
    out_rdw_r    <= out_rdw_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_rdw_r, out_taken_r, out_addr_r};

endmodule

FILE: tb/tb_bit_addressed_subleq_core.sv
`timescale 1ns / 100ps

module tb_bit_addressed_subleq_core;

  localparam bit [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    bit [21:0] next_address;
    bit        branch_taken;
    bit [63:0] read_word;
  } machine_out_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [bsq_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [bsq_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Shadow of the machine: word store and instruction bit address
  bit [63:0] store_mem [0:65535];
  bit [21:0] insn_addr = '0;

  bit [bsq_pkg::IN_TDATA_W-1:0] pending_beats[$];
  machine_out_t                 awaited_outputs[$];
  int                           beats_in_flight = 0;
  bit                           in_beat = 1'b0;

  // Words touched while building one program
  bit [15:0] patch_idx[$];
  bit [63:0] patch_word[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          stim_total = 0;
  int          mismatches = 0;
  int          n_instr = 0;
  int          n_jumps = 0;
  int          n_writes = 0;
  int          n_reads = 0;

  bit_addressed_subleq_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit [63:0] mem_pull(bit [21:0] at, int width);
    bit [63:0] v;
    bit [21:0] p;
    v = '0;
    for (int i = 0; i < width; i++) begin
      p = at + 22'(i);
      v[i] = store_mem[p[21:6]][p[5:0]];
    end
    return v;
  endfunction

  function automatic void mem_put(bit [21:0] at, bit [51:0] v);
    bit [21:0] p;
    for (int i = 0; i < 52; i++) begin
      p = at + 22'(i);
      store_mem[p[21:6]][p[5:0]] = v[i];
    end
  endfunction

  function automatic void step_machine(bit [bsq_pkg::IN_TDATA_W-1:0] beat);
    bit [15:0]    idx;
    bit [63:0]    tmp;
    bit [51:0]    insn;
    bit [51:0]    va;
    bit [51:0]    vb;
    bit [51:0]    diff;
    bit [21:0]    ip;
    bit [21:0]    a_addr;
    bit [21:0]    b_addr;
    machine_out_t r;
    idx = beat[17:2];
    r.branch_taken = 1'b0;
    r.read_word = '0;
    case (beat[1:0])
      bsq_pkg::OP_EXEC: begin
        ip = insn_addr;
        tmp = mem_pull(ip, 52);
        insn = tmp[51:0];
        a_addr = insn[21:0];
        b_addr = insn[47:26];
        tmp = mem_pull(a_addr, 52);
        va = tmp[51:0];
        tmp = mem_pull(b_addr, 52);
        vb = tmp[51:0];
        diff = va - vb;
        mem_put(a_addr, diff);
        n_instr++;
        // fall through only on a strictly positive 52-bit result
        if (diff != '0 && !diff[51]) begin
          insn_addr = ip + 22'd78;
        end else begin
          // target is read after the write-back
          tmp = mem_pull(ip + 22'd52, 22);
          insn_addr = tmp[21:0];
          r.branch_taken = 1'b1;
          n_jumps++;
        end
      end
      bsq_pkg::OP_WRITE: begin
        store_mem[idx] = beat[81:18];
        n_writes++;
      end
      bsq_pkg::OP_READ: begin
        r.read_word = store_mem[idx];
        n_reads++;
      end
      default: ;
    endcase
    r.next_address = insn_addr;
    awaited_outputs.push_back(r);
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Predict on input beats, check output beats
  always @(posedge clk) begin
    machine_out_t want;
    in_beat = in_tvalid && in_tready;
    if (rst_n) begin
      if (in_beat) step_machine(in_tdata);
      if (out_tvalid && out_tready) begin
        if (awaited_outputs.size() == 0) begin
          flag_mismatch("unrequested beat", out_tdata[63:0], '0);
        end else begin
          want = awaited_outputs.pop_front();
          beats_in_flight--;
          if (out_tdata[21:0] !== want.next_address)
            flag_mismatch("next_address", 64'(out_tdata[21:0]), 64'(want.next_address));
          if (out_tdata[22] !== want.branch_taken)
            flag_mismatch("branch_taken", 64'(out_tdata[22]), 64'(want.branch_taken));
          if (out_tdata[86:23] !== want.read_word)
            flag_mismatch("read_word", out_tdata[86:23], want.read_word);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!in_tvalid || in_beat) begin
      if (rst_n && pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata <= pending_beats.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_item(bit [1:0] op, bit [15:0] idx, bit [63:0] data);
    pending_beats.push_back({6'b0, data, idx, op});
    beats_in_flight++;
    if (op != OP_UNUSED) stim_total++;
  endtask

  task automatic wait_drained();
    while (beats_in_flight != 0) @(negedge clk);
  endtask

  function automatic void patch_bits(bit [21:0] at, bit [63:0] v, int width);
    bit [21:0] p;
    int        k;
    for (int i = 0; i < width; i++) begin
      p = at + 22'(i);
      k = -1;
      foreach (patch_idx[j]) if (patch_idx[j] == p[21:6]) k = j;
      if (k < 0) begin
        patch_idx.push_back(p[21:6]);
        patch_word.push_back(store_mem[p[21:6]]);
        k = patch_idx.size() - 1;
      end
      patch_word[k][p[5:0]] = v[i];
    end
  endfunction

  // Place operands, then the instruction and its jump target at the current
  // address, write the touched words, run, and read back the first operand.
  task automatic craft_program(bit [21:0] a_addr, bit [21:0] b_addr, bit [21:0] jump_to,
                               bit [51:0] diff, int unsigned runs);
    bit [63:0] rnd;
    bit [51:0] vb;
    bit [51:0] insn;
    bit [21:0] ip;
    wait_drained();
    patch_idx.delete();
    patch_word.delete();
    ip = insn_addr;
    rnd = {$urandom, $urandom};
    vb = rnd[51:0];
    patch_bits(b_addr, {12'b0, vb}, 52);
    patch_bits(a_addr, {12'b0, vb + diff}, 52);
    rnd = {$urandom, $urandom};
    // unused bits between and above the address fields get random junk
    insn = {rnd[3:0], b_addr, rnd[7:4], a_addr};
    patch_bits(ip, {12'b0, insn}, 52);
    patch_bits(ip + 22'd52, {42'b0, jump_to}, 22);
    foreach (patch_idx[j]) push_item(bsq_pkg::OP_WRITE, patch_idx[j], patch_word[j]);
    repeat (runs) begin
      rnd = {$urandom, $urandom};
      push_item(bsq_pkg::OP_EXEC, rnd[15:0], rnd);
    end
    push_item(bsq_pkg::OP_READ, a_addr[21:6], '0);
  endtask

  function automatic bit [21:0] pick_addr();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return 22'($urandom_range(2047));
    if (r < 70) return 22'h3FFFFF - 22'($urandom_range(2047));
    if (r < 85) return insn_addr + 22'($urandom_range(255));
    return 22'($urandom);
  endfunction

  function automatic bit [51:0] pick_diff();
    bit [63:0] rnd;
    rnd = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return 52'd0;
      1: return 52'd1;
      2: return {1'b0, {51{1'b1}}};
      3: return {1'b1, 51'd0};
      4: return {52{1'b1}};
      default: return rnd[51:0];
    endcase
  endfunction

  task automatic set_idling(int phase);
    case (phase)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 67;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 67;
      end
      default: begin
        send_idle_pct = 30;
        recv_stall_pct = 30;
      end
    endcase
  endtask

  initial begin
    bit [63:0] rnd;
    bit [21:0] a_pick;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // host access at both ends of the store, the unused op, a run on
    // cleared memory (operands alias, jump to zero)
    push_item(bsq_pkg::OP_READ, 16'h0000, '0);
    push_item(bsq_pkg::OP_READ, 16'hFFFF, '0);
    push_item(OP_UNUSED, 16'hFFFF, {64{1'b1}});
    push_item(bsq_pkg::OP_EXEC, 16'h0000, '0);
    push_item(bsq_pkg::OP_WRITE, 16'hFFFF, {64{1'b1}});
    push_item(bsq_pkg::OP_READ, 16'hFFFF, '0);
    // operand across the top of memory, then alias jumping to the top
    // address, then an instruction straddling the wrap that goes negative
    craft_program(22'h3FFFFF, 22'd200, 22'd0, 52'd5, 1);
    craft_program(22'd300, 22'd300, 22'h3FFFFF, 52'd9, 1);
    craft_program(22'd1000, 22'h3FFFC0, 22'd64, {1'b1, 51'd0}, 2);

    while (stim_total < 400) begin
      wait_drained();
      set_idling(stim_total / 100);
      if ($urandom_range(99) < 70) begin
        a_pick = pick_addr();
        craft_program(a_pick, ($urandom_range(9) == 0) ? a_pick : pick_addr(), pick_addr(),
                      pick_diff(), $urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          rnd = {$urandom, $urandom};
          push_item(2'($urandom_range(3)), 16'($urandom), rnd);
        end
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    $display("ran %0d beats: %0d instructions (%0d jumps), %0d word writes, %0d word reads",
             stim_total, n_instr, n_jumps, n_writes, n_reads);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // The time limit covers the reset sweep of all 65536 store words and the rest of the run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
